[rtl/sst_pkg.sv]
package sst_pkg;

   // Request codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_ERASE  = 2'd1;
   localparam logic [1:0] OP_TEST   = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   // Result status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_REFUSED = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;

   localparam int VALUE_W = 32;
   localparam int RANK_W  = 6;
   localparam int COUNT_W = 7;

   typedef struct packed {
      logic [RANK_W-1:0]  rank;
      logic [VALUE_W-1:0] item_value;
      logic [1:0]         op;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] item_count;
      logic [VALUE_W-1:0] read_value;
      logic [1:0]         status;
   } rsp_type;

endpackage

[rtl/sst_core.sv]
module sst_core
   import sst_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_take,
   output rsp_type rsp
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SEARCH    = 4'd1;
   localparam logic [3:0] S_CMP       = 4'd2;
   localparam logic [3:0] S_CHECK     = 4'd3;
   localparam logic [3:0] S_DECIDE    = 4'd4;
   localparam logic [3:0] S_INS_SHIFT = 4'd5;
   localparam logic [3:0] S_INS_PUT   = 4'd6;
   localparam logic [3:0] S_ERA_SHIFT = 4'd7;
   localparam logic [3:0] S_RD_WAIT   = 4'd8;
   localparam logic [3:0] S_FINISH    = 4'd9;

   logic [VALUE_W-1:0] mem [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;

   logic [3:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [1:0]         op_ff, op_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CW-1:0]      lo_ff, lo_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic [CW-1:0]      mid_ff, mid_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic               present_ff, present_in;
   logic [1:0]         status_ff, status_in;
   logic [VALUE_W-1:0] rdval_ff, rdval_in;

   logic               rd_en;
   logic [CW-1:0]      rd_addr;
   logic               wr_en;
   logic [CW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;

   logic [CW:0]        lo_hi_sum;
   logic [CW-1:0]      mid_c;
   logic [CW+RANK_W-1:0] rank_wide;
   logic [CW+RANK_W-1:0] count_wide;
   logic [CW-1:0]      idx_dec;
   logic [CW-1:0]      idx_inc;
   logic [CW:0]        idx_inc2;
   logic [CW:0]        lo_inc;
   logic [CW+COUNT_W-1:0] count_out;

   assign lo_hi_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_c      = lo_hi_sum[CW:1];
   assign rank_wide  = {{CW{1'b0}}, req.rank};
   assign count_wide = {{RANK_W{1'b0}}, count_ff};
   assign idx_dec    = idx_ff - 1'b1;
   assign idx_inc    = idx_ff + 1'b1;
   assign idx_inc2   = {1'b0, idx_ff} + 2'd2;
   assign lo_inc     = {1'b0, lo_ff} + 1'b1;
   assign count_out  = {{COUNT_W{1'b0}}, count_ff};

   // Store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr[AW-1:0]];
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      op_in      = op_ff;
      value_in   = value_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      idx_in     = idx_ff;
      present_in = present_ff;
      status_in  = status_ff;
      rdval_in   = rdval_ff;
      rd_en      = 1'b0;
      rd_addr    = lo_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = rd_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req.op;
               value_in = req.item_value;
               rdval_in = '0;
               lo_in    = '0;
               hi_in    = count_ff;
               if (req.op == OP_READ) begin
                  if (rank_wide < count_wide) begin
                     rd_en    = 1'b1;
                     rd_addr  = rank_wide[CW-1:0];
                     state_in = S_RD_WAIT;
                  end else begin
                     status_in = STAT_REFUSED;
                     state_in  = S_FINISH;
                  end
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_c;
               rd_en    = 1'b1;
               rd_addr  = mid_c;
               state_in = S_CMP;
            end else if (lo_ff < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = lo_ff;
               state_in = S_CHECK;
            end else begin
               present_in = 1'b0;
               state_in   = S_DECIDE;
            end
         end
         S_CMP: begin
            if (rd_data_ff < value_ff) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SEARCH;
         end
         S_CHECK: begin
            present_in = (rd_data_ff == value_ff);
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            case (op_ff)
               OP_INSERT: begin
                  if (present_ff) begin
                     status_in = STAT_REFUSED;
                     state_in  = S_FINISH;
                  end else if (count_ff == FULL_COUNT) begin
                     status_in = STAT_FULL;
                     state_in  = S_FINISH;
                  end else if (count_ff > lo_ff) begin
                     idx_in   = count_ff;
                     rd_en    = 1'b1;
                     rd_addr  = count_ff - 1'b1;
                     state_in = S_INS_SHIFT;
                  end else begin
                     state_in = S_INS_PUT;
                  end
               end
               OP_ERASE: begin
                  if (!present_ff) begin
                     status_in = STAT_REFUSED;
                     state_in  = S_FINISH;
                  end else if (lo_inc < {1'b0, count_ff}) begin
                     idx_in   = lo_ff;
                     rd_en    = 1'b1;
                     rd_addr  = lo_inc[CW-1:0];
                     state_in = S_ERA_SHIFT;
                  end else begin
                     count_in  = count_ff - 1'b1;
                     status_in = STAT_OK;
                     state_in  = S_FINISH;
                  end
               end
               default: begin
                  status_in = present_ff ? STAT_OK : STAT_REFUSED;
                  state_in  = S_FINISH;
               end
            endcase
         end
         S_INS_SHIFT: begin
            // move the cell read last cycle up one place
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
            idx_in  = idx_dec;
            if (idx_dec > lo_ff) begin
               rd_en   = 1'b1;
               rd_addr = idx_dec - 1'b1;
            end else begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            wr_en     = 1'b1;
            wr_addr   = lo_ff;
            wr_data   = value_ff;
            count_in  = count_ff + 1'b1;
            status_in = STAT_OK;
            state_in  = S_FINISH;
         end
         S_ERA_SHIFT: begin
            // move the cell read last cycle down one place
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
            idx_in  = idx_inc;
            if (idx_inc2 < {1'b0, count_ff}) begin
               rd_en   = 1'b1;
               rd_addr = idx_inc2[CW-1:0];
            end else begin
               count_in  = count_ff - 1'b1;
               status_in = STAT_OK;
               state_in  = S_FINISH;
            end
         end
         S_RD_WAIT: begin
            rdval_in  = rd_data_ff;
            status_in = STAT_OK;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff      <= op_in;
      value_ff   <= value_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      idx_ff     <= idx_in;
      present_ff <= present_in;
      status_ff  <= status_in;
      rdval_ff   <= rdval_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = (state_ff == S_FINISH);
   assign rsp.status     = status_ff;
   assign rsp.read_value = rdval_ff;
   assign rsp.item_count = count_out[COUNT_W-1:0];

endmodule

[rtl/sorted_set_table.sv]
// Channel  | Dir | Beat contents (tdata, low bit first)                | Accepted when
// req_     | in  | op[1:0], item_value[33:2], rank[39:34]              | req_tvalid & req_tready
// rsp_     | out | status[1:0], read_value[33:2], item_count[40:34]    | rsp_tvalid & rsp_tready
//
// One request at a time: the engine is ready for a request only when idle.
// A binary search reads the value store (registered read) and then compares
// for each halving of the held range; a membership test then reads and checks
// the cell at the found position, if any. An insert moves each cell from that
// position up one place, and an erase each cell above it down one place, one
// cell at a time through the single write port. A read by rank reads one cell.
// Reset is synchronous: the count clears at once, the store is left as is.
// A new request is taken while a finished result still waits in the
// output register; rsp_tready low stalls only the engine's final step.
module sorted_set_table
   import sst_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // op[1:0], item_value[33:2], rank[39:34]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // status[1:0], read_value[33:2], item_count[40:34]
);

   req_type req;
   rsp_type core_rsp;
   logic    core_valid;
   logic    core_take;

   rsp_type out_ff;
   logic    out_valid_ff;

   // unpack the request beat
   assign req.op         = req_tdata[1:0];
   assign req.item_value = req_tdata[33:2];
   assign req.rank       = req_tdata[39:34];

   sst_core #(
      .CAPACITY (CAPACITY)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .rsp_valid (core_valid),
      .rsp_take  (core_take),
      .rsp       (core_rsp)
   );

   // load the output register when it is empty or being drained this cycle
   assign core_take = core_valid && (!out_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (core_take) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (core_take) begin
         out_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff.item_count, out_ff.read_value, out_ff.status};

endmodule
